FILE: hw/rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack package
// Shared sizes, codes and types for the two-stacks-in-one-store block.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Store size and the widths that follow from it.
    localparam int DEPTH    = 64;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DATA_W   = 32;
    localparam int LEFT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int ACTION_W = 3;

    // Depths of the internal queues.
    localparam int CQ_DEPTH = 2;
    localparam int RQ_DEPTH = 2;

    // Input action codes.
    localparam logic [ACTION_W-1:0] ACT_PUSH_A = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_A  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LIST_A = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PUSH_B = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_B  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_LIST_B = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Decoded operation kind.
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_LIST
    } t_op;

    // One classified command from the front end.
    typedef struct packed {
        t_op               op;
        logic              is_b;
        logic [DATA_W-1:0] value;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [LEFT_W-1:0]   left;
        logic                last;
    } t_res;

    // Store slot of entry n (0 is the bottom) of stack A or stack B.
    function automatic logic [ADDR_W-1:0] slot_of(logic is_b, logic [CNT_W-1:0] n);
        logic [ADDR_W-1:0] idx;
        idx = n[ADDR_W-1:0];
        return is_b ? (ADDR_W'(DEPTH - 1) - idx) : idx;
    endfunction

endpackage

FILE: hw/rtl/dual_stack_shared_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared array
// Two LIFO stacks in one store: A grows up from slot 0, B grows down from
// the top slot. Push, pop and list actions on either stack.
//
// Channel   Direction  Handshake             Payload
// input     in         push / full           i_action, i_push_value
// result    out        pop / empty           o_data_value, o_status,
//                                            o_entries_left, o_last
//
// Push and pop sustain one item per cycle while results are popped; a list
// of n entries occupies the back end with one store read per entry, while
// later items queue. The single store port of the back end sets that rate.
// An item's first result passes the front stage register, the command queue,
// the read stage and the result queue on its way to the result ports. Reset is
// synchronous and clears both counts and all queues; the store needs no
// clearing. Either side may stall at any time: a full result queue holds the
// back end, which fills the command queue, which then raises full.
// ----------------------------------------------------------------------------
module dual_stack_shared_array import dss_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [DATA_W-1:0]   i_push_value,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [DATA_W-1:0]   o_data_value,
    output logic [STATUS_W-1:0]        o_status,
    output logic [LEFT_W-1:0]          o_entries_left,
    output logic                       o_last
);

    logic f_valid;
    t_cmd f_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_rd;
    logic res_valid;
    t_res res;

    // Accept and classify input items.
    dss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .i_q_full     (q_full),
        .o_cmd_valid  (f_valid),
        .o_cmd        (f_cmd)
    );

    // Decoupling queue between front and back.
    dss_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Execute commands against the shared store.
    dss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_rd    (q_rd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_rd    (pop)
    );

    // Result ports.
    assign empty          = !res_valid;
    assign o_data_value   = res.data;
    assign o_status       = res.status;
    assign o_entries_left = res.left;
    assign o_last         = res.last;

endmodule

FILE: hw/rtl/dss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack front end
// Accepts input items, decodes the action code and drops unused codes.
// ----------------------------------------------------------------------------
module dss_front import dss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [DATA_W-1:0]   i_push_value,
    input  logic                i_q_full,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    logic w_accept;
    logic w_code_ok;
    t_cmd w_dec;

    // The stage holds when its command cannot move into the queue.
    assign full        = r_valid && i_q_full;
    assign w_accept    = push && !full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Decode the action code into an operation and a stack select.
    always_comb begin
        w_code_ok   = 1'b1;
        w_dec.value = i_push_value;
        w_dec.is_b  = 1'b0;
        w_dec.op    = OP_PUSH;
        unique case (i_action)
            ACT_PUSH_A: begin
                w_dec.op = OP_PUSH;
            end
            ACT_POP_A: begin
                w_dec.op = OP_POP;
            end
            ACT_LIST_A: begin
                w_dec.op = OP_LIST;
            end
            ACT_PUSH_B: begin
                w_dec.op   = OP_PUSH;
                w_dec.is_b = 1'b1;
            end
            ACT_POP_B: begin
                w_dec.op   = OP_POP;
                w_dec.is_b = 1'b1;
            end
            ACT_LIST_B: begin
                w_dec.op   = OP_LIST;
                w_dec.is_b = 1'b1;
            end
            default: begin
                w_code_ok = 1'b0;
            end
        endcase
    end

    // Stage register; an unused code is taken and then forgotten.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept && w_code_ok) begin
            r_valid <= 1'b1;
            r_cmd   <= w_dec;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

endmodule

FILE: hw/rtl/dss_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack command queue
// Short queue that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
module dss_cmd_queue import dss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(CQ_DEPTH);
    localparam int OCC_W = $clog2(CQ_DEPTH + 1);

    t_cmd             r_mem [CQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [OCC_W-1:0] r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == OCC_W'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + OCC_W'(w_wr) - OCC_W'(w_rd);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/dss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack back end
// Holds the shared store and both counts, executes commands and buffers
// the results.
// ----------------------------------------------------------------------------
module dss_back import dss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_rd,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_rd
);

    localparam int RP_W  = $clog2(RQ_DEPTH);
    localparam int ROC_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic {
        S_RUN,
        S_LIST
    } t_state;

    // Control and store.
    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b;
    logic              r_list_b;
    logic [CNT_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Read stage and result queue.
    logic              r_s1_valid;
    logic              r_s1_read;
    t_res              r_s1_res;
    t_res              r_rq [RQ_DEPTH];
    logic [RP_W-1:0]   r_rq_wp;
    logic [RP_W-1:0]   r_rq_rp;
    logic [ROC_W-1:0]  r_rq_cnt;

    // Next values.
    t_state            n_state;
    logic [CNT_W-1:0]  n_cnt_a;
    logic [CNT_W-1:0]  n_cnt_b;
    logic              n_list_b;
    logic [CNT_W-1:0]  n_idx;
    logic              n_s1_valid;
    logic              n_s1_read;
    t_res              n_s1_res;

    logic              w_res_rd;
    logic [ROC_W:0]    w_occ;
    logic              w_can_issue;
    logic              w_wr;
    logic [ADDR_W-1:0] w_addr;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_list_cnt;
    t_res              w_enq;

    // A new step may start only if its result will find room in the queue.
    assign w_res_rd    = i_res_rd && o_res_valid;
    assign w_occ       = {1'b0, r_rq_cnt} + (ROC_W + 1)'(r_s1_valid) - (ROC_W + 1)'(w_res_rd);
    assign w_can_issue = (w_occ < (ROC_W + 1)'(RQ_DEPTH));

    assign w_cnt      = i_cmd.is_b ? r_cnt_b : r_cnt_a;
    assign w_list_cnt = r_list_b ? r_cnt_b : r_cnt_a;
    assign w_sum      = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};

    // Command execution: one store access per cycle while the result queue has room.
    always_comb begin
        n_state    = r_state;
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_list_b   = r_list_b;
        n_idx      = r_idx;
        n_s1_valid = 1'b0;
        n_s1_read  = 1'b0;
        n_s1_res   = '0;
        o_cmd_rd   = 1'b0;
        w_wr       = 1'b0;
        w_addr     = '0;
        unique case (r_state)
            S_RUN: begin
                if (w_can_issue && i_cmd_valid) begin
                    o_cmd_rd         = 1'b1;
                    n_s1_valid       = 1'b1;
                    n_s1_res.last    = 1'b1;
                    n_s1_res.status  = ST_OK;
                    unique case (i_cmd.op)
                        OP_PUSH: begin
                            if (w_sum >= (CNT_W + 1)'(DEPTH)) begin
                                n_s1_res.status = ST_FULL;
                                n_s1_res.left   = LEFT_W'(w_cnt);
                            end else begin
                                w_wr          = 1'b1;
                                w_addr        = slot_of(i_cmd.is_b, w_cnt);
                                n_s1_res.left = LEFT_W'(w_cnt + 1'b1);
                                if (i_cmd.is_b) begin
                                    n_cnt_b = w_cnt + 1'b1;
                                end else begin
                                    n_cnt_a = w_cnt + 1'b1;
                                end
                            end
                        end
                        OP_POP: begin
                            if (w_cnt == '0) begin
                                n_s1_res.status = ST_EMPTY;
                            end else begin
                                n_s1_read     = 1'b1;
                                w_addr        = slot_of(i_cmd.is_b, w_cnt - 1'b1);
                                n_s1_res.left = LEFT_W'(w_cnt - 1'b1);
                                if (i_cmd.is_b) begin
                                    n_cnt_b = w_cnt - 1'b1;
                                end else begin
                                    n_cnt_a = w_cnt - 1'b1;
                                end
                            end
                        end
                        OP_LIST: begin
                            if (w_cnt == '0) begin
                                n_s1_res.status = ST_EMPTY;
                            end else begin
                                // Top element now; the rest walk down in S_LIST.
                                n_s1_read     = 1'b1;
                                w_addr        = slot_of(i_cmd.is_b, w_cnt - 1'b1);
                                n_s1_res.left = LEFT_W'(w_cnt);
                                n_s1_res.last = (w_cnt == CNT_W'(1));
                                if (w_cnt != CNT_W'(1)) begin
                                    n_state  = S_LIST;
                                    n_list_b = i_cmd.is_b;
                                    n_idx    = w_cnt - CNT_W'(2);
                                end
                            end
                        end
                        default: begin
                            n_s1_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (w_can_issue) begin
                    n_s1_valid      = 1'b1;
                    n_s1_read       = 1'b1;
                    w_addr          = slot_of(r_list_b, r_idx);
                    n_s1_res.status = ST_OK;
                    n_s1_res.left   = LEFT_W'(w_list_cnt);
                    n_s1_res.last   = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_RUN;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // State, counts and the read stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_s1_valid <= n_s1_valid;
        end
        r_list_b  <= n_list_b;
        r_idx     <= n_idx;
        r_s1_read <= n_s1_read;
        r_s1_res  <= n_s1_res;
    end

    // Shared store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_addr] <= i_cmd.value;
        end
        if (n_s1_read) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // Fold the read data into the result as it enters the queue.
    always_comb begin
        w_enq = r_s1_res;
        if (r_s1_read) begin
            w_enq.data = r_rd_data;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= '0;
            r_rq_rp  <= '0;
            r_rq_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_rq_wp <= (r_rq_wp == RP_W'(RQ_DEPTH - 1)) ? '0 : r_rq_wp + 1'b1;
            end
            if (w_res_rd) begin
                r_rq_rp <= (r_rq_rp == RP_W'(RQ_DEPTH - 1)) ? '0 : r_rq_rp + 1'b1;
            end
            r_rq_cnt <= r_rq_cnt + ROC_W'(r_s1_valid) - ROC_W'(w_res_rd);
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_rq[r_rq_wp] <= w_enq;
        end
    end

    assign o_res_valid = (r_rq_cnt != '0);
    assign o_res       = r_rq[r_rq_rp];

    // The result queue never overflows.
    a_rq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rq_cnt <= ROC_W'(RQ_DEPTH))
        else $error("result queue overflow");

    // The two stacks never hold more than the store.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum <= (CNT_W + 1)'(DEPTH))
        else $error("stack counts exceed store depth");

    // A list walk stays below the listed stack's count.
    a_list_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_idx < w_list_cnt))
        else $error("list index beyond stack top");

    // A refused push only happens with the store completely used.
    a_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_res.status == ST_FULL) |-> (w_sum == (CNT_W + 1)'(DEPTH)))
        else $error("full status with free slots");

endmodule

FILE: tb/dual_stack_shared_array_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared array testbench
// Drives push, pop and list actions on both stacks through the input queue
// and checks every result against a cycle-free prediction of the two stacks.
// A directed opening covers empty stacks, extreme values and unused codes.
// A random part then fills the store, including refused pushes, and ends in a
// mixed sequence. Both sides idle at random. One long receiver stall forces
// the input side to back up.
// ----------------------------------------------------------------------------
module dual_stack_shared_array_test;
    import dss_pkg::*;

    // Action codes that the block ignores.
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MIXED_ITEMS   = 35;
    localparam int REPORT_LIMIT  = 10;

    // Prediction of both stacks and the store of expected results.
    class stack_scoreboard;
        logic [DATA_W-1:0] slots [DEPTH];
        int unsigned       depth_a;
        int unsigned       depth_b;
        t_res              expected_q [$];
        int unsigned       n_checked;
        int unsigned       n_mismatch;
        int unsigned       n_refused;
        int unsigned       n_lists;

        function new();
            depth_a    = 0;
            depth_b    = 0;
            n_checked  = 0;
            n_mismatch = 0;
            n_refused  = 0;
            n_lists    = 0;
        endfunction

        // Slot of entry n, counted from the bottom of the chosen stack.
        function int unsigned slot_index(bit is_b, int unsigned n);
            return is_b ? DEPTH - 1 - n : n;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Note one accepted input transfer and queue its results.
        function void note_input(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
            t_res        r;
            t_op         op;
            bit          is_b;
            int unsigned depth;
            int unsigned n;
            if (act > ACT_LIST_B) begin
                return;
            end
            is_b  = (act >= ACT_PUSH_B);
            depth = is_b ? depth_b : depth_a;
            if (act == ACT_PUSH_A || act == ACT_PUSH_B) begin
                op = OP_PUSH;
            end else if (act == ACT_POP_A || act == ACT_POP_B) begin
                op = OP_POP;
            end else begin
                op = OP_LIST;
            end
            r.data = '0;
            r.last = 1'b1;
            if (op == OP_PUSH) begin
                if (depth_a + depth_b >= DEPTH) begin
                    r.status = ST_FULL;
                    n_refused++;
                end else begin
                    slots[slot_index(is_b, depth)] = val;
                    depth++;
                    r.status = ST_OK;
                end
                r.left = LEFT_W'(depth);
                expected_q.push_back(r);
            end else if (depth == 0) begin
                // Pop or list on an empty stack gives a single empty status.
                r.status = ST_EMPTY;
                r.left   = '0;
                expected_q.push_back(r);
            end else if (op == OP_POP) begin
                depth--;
                r.data   = slots[slot_index(is_b, depth)];
                r.status = ST_OK;
                r.left   = LEFT_W'(depth);
                expected_q.push_back(r);
            end else begin
                // A list walks the stack from top to bottom and leaves it as is.
                n_lists++;
                for (n = depth; n > 0; n--) begin
                    r.data   = slots[slot_index(is_b, n - 1)];
                    r.status = ST_OK;
                    r.left   = LEFT_W'(depth);
                    r.last   = (n == 1);
                    expected_q.push_back(r);
                end
            end
            if (is_b) begin
                depth_b = depth;
            end else begin
                depth_a = depth;
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(t_res got);
            t_res want;
            n_checked++;
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= REPORT_LIMIT) begin
                    $display("ERROR: unexpected result data=%h status=%0d left=%0d last=%0d",
                             got.data, got.status, got.left, got.last);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.data !== want.data || got.status !== want.status ||
                got.left !== want.left || got.last !== want.last) begin
                n_mismatch++;
                if (n_mismatch <= REPORT_LIMIT) begin
                    $display("ERROR: result %0d expected data=%h status=%0d left=%0d last=%0d",
                             n_checked, want.data, want.status, want.left, want.last);
                    $display("       got      data=%h status=%0d left=%0d last=%0d",
                             got.data, got.status, got.left, got.last);
                end
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic [ACTION_W-1:0]        i_action;
    logic signed [DATA_W-1:0]   i_push_value;
    logic                       empty;
    logic                       pop;
    logic signed [DATA_W-1:0]   o_data_value;
    logic [STATUS_W-1:0]        o_status;
    logic [LEFT_W-1:0]          o_entries_left;
    logic                       o_last;

    stack_scoreboard sb;
    bit              tx_steady;
    bit              hold_request;
    int unsigned     items_sent;

    dual_stack_shared_array dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .empty          (empty),
        .pop            (pop),
        .o_data_value   (o_data_value),
        .o_status       (o_status),
        .o_entries_left (o_entries_left),
        .o_last         (o_last)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Push values lean toward the extremes now and then.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and wait for its transfer.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        push         <= 1'b1;
        i_action     <= act;
        i_push_value <= val;
        do @(posedge i_clk); while (full);
        sb.note_input(act, val);
        if (act <= ACT_LIST_B) begin
            items_sent++;
        end
    endtask

    // Hold the input side idle, with noise on the payload.
    task automatic idle_input(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            push         <= 1'b0;
            i_action     <= ACTION_W'($urandom);
            i_push_value <= $urandom;
        end
    endtask

    task automatic send_with_gap(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
        send_item(act, val);
        idle_input(pick_gap(tx_steady));
    endtask

    // Result side: random pop gaps, one long hold-off on request.
    initial begin : result_side
        int unsigned rx_gap;
        int unsigned hold_left;
        t_res        got;
        rx_gap    = 0;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (rx_gap > 0) begin
                pop <= 1'b0;
                rx_gap--;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                got.data   = o_data_value;
                got.status = o_status;
                got.left   = o_entries_left;
                got.last   = o_last;
                sb.check_result(got);
                // Every third stretch of 40 results runs without gaps.
                rx_gap = pick_gap(((sb.n_checked / 40) % 3) == 0);
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles, %0d results still expected",
                         quiet, sb.pending());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin : stimulus
        int unsigned n;
        bit          favor_b;
        int unsigned r;
        bit          is_b;
        sb           = new();
        items_sent   = 0;
        tx_steady    = 1'b0;
        hold_request = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_action     = ACT_PUSH_A;
        i_push_value = '0;
        i_rst_n      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty stacks, extreme values, unused codes, short lists.
        send_with_gap(ACT_LIST_A, $urandom);
        send_with_gap(ACT_LIST_B, $urandom);
        send_with_gap(ACT_POP_A, $urandom);
        send_with_gap(ACT_POP_B, $urandom);
        send_with_gap(ACT_PUSH_A, 32'h7FFF_FFFF);
        send_with_gap(ACT_PUSH_A, 32'h8000_0000);
        send_with_gap(ACT_PUSH_A, '0);
        send_with_gap(ACT_PUSH_A, '1);
        send_with_gap(ACT_PUSH_B, 32'h8000_0000);
        send_with_gap(ACT_PUSH_B, 32'h7FFF_FFFF);
        send_with_gap(ACT_PUSH_B, 32'h5555_5555);
        send_with_gap(ACT_PUSH_B, 32'hAAAA_AAAA);
        send_with_gap(ACT_LIST_A, $urandom);
        send_with_gap(ACT_LIST_B, $urandom);
        send_with_gap(ACT_SPARE_6, $urandom);
        send_with_gap(ACT_SPARE_7, $urandom);
        send_with_gap(ACT_POP_A, $urandom);
        send_with_gap(ACT_POP_B, $urandom);
        send_with_gap(ACT_LIST_A, $urandom);
        send_with_gap(ACT_LIST_B, $urandom);

        // Fill the store, mostly into one stack, while the result side holds off.
        hold_request = 1'b1;
        tx_steady    = 1'b1;
        favor_b      = $urandom_range(0, 1);
        n            = 0;
        while (sb.depth_a + sb.depth_b < DEPTH) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_with_gap($urandom_range(0, 1) ? ACT_LIST_B : ACT_LIST_A, $urandom);
            end else begin
                is_b = (r < 90) ? favor_b : !favor_b;
                send_with_gap(is_b ? ACT_PUSH_B : ACT_PUSH_A, pick_value());
            end
            n++;
            if (n == 24) begin
                tx_steady = 1'b0;
            end
        end

        // The store is full: pushes are refused, then both stacks are listed.
        send_with_gap(ACT_PUSH_A, pick_value());
        send_with_gap(ACT_PUSH_B, pick_value());
        send_with_gap(ACT_LIST_A, $urandom);
        send_with_gap(ACT_LIST_B, $urandom);

        // Mixed sequence that leans toward pops so the stacks drain again.
        n = 0;
        while (n < MIXED_ITEMS) begin
            r    = $urandom_range(0, 99);
            is_b = $urandom_range(0, 1);
            tx_steady = (n >= 20);
            if (r < 30) begin
                send_with_gap(is_b ? ACT_PUSH_B : ACT_PUSH_A, pick_value());
                n++;
            end else if (r < 65 || r >= 85) begin
                send_with_gap(is_b ? ACT_POP_B : ACT_POP_A, $urandom);
                n++;
            end else if (r < 80) begin
                send_with_gap(is_b ? ACT_LIST_B : ACT_LIST_A, $urandom);
                n++;
            end else begin
                send_with_gap(is_b ? ACT_SPARE_7 : ACT_SPARE_6, $urandom);
            end
        end
        idle_input(1);

        // Drain, then allow time for any stray result to show up.
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d actions on both stacks, %0d lists, %0d refused pushes,",
                 items_sent, sb.n_lists, sb.n_refused);
        $display("with %0d results checked and %0d mismatches.", sb.n_checked, sb.n_mismatch);
        if (sb.n_mismatch == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_front.sv
hw/rtl/dss_cmd_queue.sv
hw/rtl/dss_back.sv
hw/rtl/dual_stack_shared_array.sv
tb/dual_stack_shared_array_test.sv
